// ===== rtl/bte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character lookup functions for the byte-to-text encoder.
// Depends on nothing; every other file of the block refers to it by scoped names.
package bte_pkg;

   // Mode register codes.
   localparam logic [2:0] MODE_LATIN1 = 3'd0;
   localparam logic [2:0] MODE_ASCII  = 3'd1;
   localparam logic [2:0] MODE_B64    = 3'd2;
   localparam logic [2:0] MODE_B64URL = 3'd3;
   localparam logic [2:0] MODE_HEX    = 3'd4;

   localparam logic [7:0] PAD_CHAR    = 8'h3d;  // '='
   localparam int         QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      JOB_RAW = 2'd0,
      JOB_HEX = 2'd1,
      JOB_B64 = 2'd2
   } job_kind_type;

   // One unit of work handed from the front to the back.
   typedef struct packed {
      job_kind_type kind;
      logic         url;       // base64url alphabet
      logic [23:0]  value;     // raw byte in [7:0], or a base64 group, oldest byte on top
      logic [1:0]   last_idx;  // index of the final character of the job
      logic [1:0]   sig_last;  // last base64 character that carries data; later ones pad
   } job_type;

   function automatic logic [7:0] b64_char(input logic [5:0] idx, input logic url);
      logic [7:0] c;
      logic [7:0] wide;
      wide = {2'b00, idx};
      if (idx < 6'd26) begin
         c = wide + 8'h41;
      end else if (idx < 6'd52) begin
         c = wide + 8'h47;
      end else if (idx < 6'd62) begin
         c = wide - 8'd4;
      end else if (idx == 6'd62) begin
         c = url ? 8'h2d : 8'h2b;
      end else begin
         c = url ? 8'h5f : 8'h2f;
      end
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = {4'h0, nib} + 8'h30;
      end else begin
         c = {4'h0, nib} + 8'h57;
      end
      return c;
   endfunction

endpackage

// ===== rtl/bte_front.sv =====
`timescale 1ns / 1ps
// Front end: holds the mode register and the base64 carry, classifies each request
// and builds a job for the back end. Depends on bte_pkg.
module bte_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_data,
   input  logic              req_accept,
   input  logic [7:0]        data_byte,
   input  logic              byte_valid,
   input  logic              flush,
   output logic              push,
   output bte_pkg::job_type  push_job
);

   logic [2:0]  mode_ff;
   logic [15:0] carry_bytes_ff, carry_bytes_in;
   logic [1:0]  carry_count_ff, carry_count_in;

   logic [1:0]  cnt_old;
   logic [2:0]  cnt_new;
   logic [7:0]  new0, new1;
   logic        emit_b64;
   logic        has_job;

   assign csr_ready = 1'b1;

   always_comb begin
      cnt_old  = (carry_count_ff == 2'd3) ? 2'd0 : carry_count_ff;
      cnt_new  = {1'b0, cnt_old} + {2'b00, byte_valid};
      new0     = (byte_valid && cnt_old == 2'd0) ? data_byte : carry_bytes_ff[7:0];
      new1     = (byte_valid && cnt_old == 2'd1) ? data_byte : carry_bytes_ff[15:8];
      emit_b64 = (cnt_new == 3'd3) || (flush && cnt_new != 3'd0);

      has_job           = 1'b0;
      push_job.kind     = bte_pkg::JOB_RAW;
      push_job.url      = 1'b0;
      push_job.value    = {16'h0000, data_byte};
      push_job.last_idx = 2'd0;
      push_job.sig_last = 2'd0;
      carry_bytes_in    = carry_bytes_ff;
      carry_count_in    = carry_count_ff;

      case (mode_ff)
         bte_pkg::MODE_LATIN1: begin
            has_job = byte_valid;
         end
         bte_pkg::MODE_ASCII: begin
            has_job        = byte_valid;
            push_job.value = {17'h00000, data_byte[6:0]};
         end
         bte_pkg::MODE_HEX: begin
            has_job           = byte_valid;
            push_job.kind     = bte_pkg::JOB_HEX;
            push_job.last_idx = 2'd1;
         end
         bte_pkg::MODE_B64, bte_pkg::MODE_B64URL: begin
            has_job           = emit_b64;
            push_job.kind     = bte_pkg::JOB_B64;
            push_job.url      = (mode_ff == bte_pkg::MODE_B64URL);
            push_job.value    = {new0,
                                 (cnt_new > 3'd1) ? new1 : 8'h00,
                                 (cnt_new > 3'd2) ? data_byte : 8'h00};
            push_job.sig_last = cnt_new[1:0];
            push_job.last_idx = push_job.url ? cnt_new[1:0] : 2'd3;
            if (emit_b64) begin
               carry_bytes_in = 16'h0000;
               carry_count_in = 2'd0;
            end else begin
               carry_bytes_in = {(cnt_new > 3'd1) ? new1 : 8'h00,
                                 (cnt_new != 3'd0) ? new0 : 8'h00};
               carry_count_in = cnt_new[1:0];
            end
         end
         default: begin
            has_job = 1'b0;
         end
      endcase

      if (flush) begin
         carry_bytes_in = 16'h0000;
         carry_count_in = 2'd0;
      end
   end

   assign push = req_accept && has_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= bte_pkg::MODE_LATIN1;
         carry_bytes_ff <= 16'h0000;
         carry_count_ff <= 2'd0;
      end else if (csr_valid && csr_ready) begin
         mode_ff        <= csr_data;
         carry_bytes_ff <= 16'h0000;
         carry_count_ff <= 2'd0;
      end else if (req_accept) begin
         carry_bytes_ff <= carry_bytes_in;
         carry_count_ff <= carry_count_in;
      end
   end

endmodule

// ===== rtl/bte_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between front and back end, kept in flip-flops.
// Depends on bte_pkg.
module bte_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bte_pkg::job_type  push_job,
   input  logic              pop,
   output logic              head_valid,
   output bte_pkg::job_type  head_job,
   output logic              full
);

   localparam int Depth = bte_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   bte_pkg::job_type entry_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CntW'(Depth))
      else $error("job queue count overran its depth");
   assert property (@(posedge clock) disable iff (reset)
                    (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("job queue count did not follow a lone push");
   assert property (@(posedge clock) disable iff (reset)
                    (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("job queue pointers disagree while empty");

endmodule

// ===== rtl/bte_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the head job one character per cycle while the response channel
// is ready, and drives the registered response channel. Depends on bte_pkg.
module bte_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  bte_pkg::job_type  head_job,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);

   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load, advance;
   logic [5:0] sextet;

   assign load    = !rsp_valid_ff || rsp_tready;
   assign advance = head_valid && load;

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = head_job.value[23:18];
         2'd1:    sextet = head_job.value[17:12];
         2'd2:    sextet = head_job.value[11:6];
         default: sextet = head_job.value[5:0];
      endcase

      case (head_job.kind)
         bte_pkg::JOB_RAW: rsp_data_in = head_job.value[7:0];
         bte_pkg::JOB_HEX: rsp_data_in = bte_pkg::hex_char((idx_ff == 2'd0) ?
                                           head_job.value[7:4] : head_job.value[3:0]);
         bte_pkg::JOB_B64: rsp_data_in = (idx_ff > head_job.sig_last) ? bte_pkg::PAD_CHAR :
                                           bte_pkg::b64_char(sextet, head_job.url);
         default:          rsp_data_in = 8'h00;
      endcase

      rsp_last_in = (idx_ff == head_job.last_idx);
      idx_in      = idx_ff;
      if (advance) begin
         idx_in = rsp_last_in ? 2'd0 : idx_ff + 2'd1;
      end
   end

   assign pop = advance && rsp_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            rsp_valid_ff <= head_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset) (idx_ff != 2'd0) |-> head_valid)
      else $error("character index left mid-job without a job at the head");
   assert property (@(posedge clock) disable iff (reset)
                    head_valid |-> (idx_ff <= head_job.last_idx))
      else $error("character index ran past the end of the job");
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid_ff)
      else $error("a character was taken from the job but not presented");

endmodule

// ===== rtl/streaming_bytes_to_text_encoder_unit.sv =====
`timescale 1ns / 1ps
// Top level of the streaming byte-to-text encoder (latin1, ascii, hex, base64, base64url).
// Depends on bte_pkg, bte_front, bte_queue and bte_back.
//
// Raw bytes come in on the request channel and leave as text characters on the response
// channel, one character per response. The mode register (csr_data: 0 latin1, 1 ascii,
// 2 base64 with '=' padding, 3 base64url without padding, 4 lower-case hex; 5 to 7 emit
// nothing) is to be written by the user only while the block is idle; the block itself
// does not enforce this. Every write also clears the base64 carry. A request with
// req_tuser high carries a byte; req_tlast high is a flush that encodes the carried bytes
// (after this request's own byte) and clears the carry. A request with neither bit set
// does nothing. The last character caused by a request is marked with rsp_tlast. The
// front end takes one request per cycle while its two-entry job queue has room, and the
// back end turns each job into characters at one per cycle while the response channel is
// ready. A request makes one character in latin1 and ascii, two in hex, and in base64
// zero for most bytes, four for every third byte and two to four for a flush that has
// bytes to encode, about 1.33 per byte on average. The single-character response port
// sets the overall rate. The first character of a request passes through the job queue
// and then the response register before it is presented.
module streaming_bytes_to_text_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   // Configuration write channel.
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_data,     // mode
   // Request channel.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tuser,    // [0] byte_valid
   input  logic       req_tlast,    // flush
   // Response channel.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] text_char
   output logic       rsp_tlast     // last_of_run
);

   logic             req_accept;
   logic             push;
   bte_pkg::job_type push_job;
   logic             pop;
   logic             head_valid;
   bte_pkg::job_type head_job;
   logic             queue_full;

   // The front end never waits on the back end directly; only a full queue stalls requests.
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   bte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_accept (req_accept),
      .data_byte  (req_tdata),
      .byte_valid (req_tuser),
      .flush      (req_tlast),
      .push       (push),
      .push_job   (push_job)
   );

   bte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .full       (queue_full)
   );

   // The back end owns the response register, so a waiting character blocks the front
   // end from taking the next request only once the job queue is full.
   bte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
